// ----- rtl/core/ivl_pkg.sv -----
// ivl_pkg: constants, command codes and shared types of the indexed value list.
// Used by every file in rtl/core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ivl_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int CMD_W    = 3;
  localparam int GRP_SIZE = 8;
  localparam int SUB_W    = 3;
  localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_W    = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;

  localparam logic [POS_W-1:0]  CAP_COUNT = POS_W'(CAPACITY);
  localparam logic [DATA_W-1:0] NEG_ONE   = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_FRONT = 3'd0,
    CMD_ADD_BACK  = 3'd1,
    CMD_ADD_AT    = 3'd2,
    CMD_REM_FRONT = 3'd3,
    CMD_REM_BACK  = 3'd4,
    CMD_REM_AT    = 3'd5,
    CMD_READ      = 3'd6,
    CMD_CLEAR     = 3'd7
  } cmd_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/ivl_if.sv -----
// ivl_in_if / ivl_out_if: valid-ready channels for commands and results.
// Depends on ivl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ivl_in_if;
  logic                                valid;
  logic                                ready;
  logic [ivl_pkg::CMD_W-1:0]           cmd;
  logic [ivl_pkg::POS_W-1:0]           position;
  logic signed [ivl_pkg::DATA_W-1:0]   item_value;

  modport source (output valid, cmd, position, item_value, input ready);
  modport sink   (input valid, cmd, position, item_value, output ready);
endinterface

interface ivl_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ivl_pkg::DATA_W-1:0]   read_value;
  logic                                ok;
  logic [ivl_pkg::POS_W-1:0]           length;

  modport source (output valid, read_value, ok, length, input ready);
  modport sink   (input valid, read_value, ok, length, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/ivl_cell.sv -----
// ivl_cell: one storage slot of the shifting list; takes its left or right
// neighbor, the new value, or holds. Depends on ivl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ivl_cell (
  input  wire                             clk,
  input  wire ivl_pkg::cell_cmd_t         cmd,
  input  wire [ivl_pkg::POS_W-1:0]        my_idx,
  input  wire [ivl_pkg::DATA_W-1:0]       left_val,
  input  wire [ivl_pkg::DATA_W-1:0]       right_val,
  output logic [ivl_pkg::DATA_W-1:0]      val
);

  logic [ivl_pkg::DATA_W-1:0] val_r;
  logic [ivl_pkg::DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (my_idx == cmd.pos) begin
        val_nxt = cmd.val;
      end else if (my_idx > cmd.pos) begin
        val_nxt = left_val;
      end
    end else if (cmd.rem && (my_idx >= cmd.pos)) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule
`default_nettype wire

// ----- rtl/core/indexed_value_list_unit.sv -----
// indexed_value_list_unit: top level of the indexed value list.
// Depends on ivl_pkg, ivl_if (ivl_in_if, ivl_out_if) and ivl_cell.
//
// Usage:
//  - in_ch carries one command per transaction: cmd, position, item_value.
//  - out_ch returns exactly one result per command: read_value, ok and the
//    list length after the command. read_value is -1 unless a remove or read
//    succeeded.
//  - The command is registered on acceptance, the first select into the group
//    registers, then the result into the output register. Commands are taken
//    one at a time by a three-step sequencer: the cell chain shifts and a first
//    8:1 select is registered per group of cells, then the group holding the
//    wanted entry is picked into the output register.
//  - The output register decouples the sides: the next command is accepted
//    while a result still waits; the sequencer waits only if a new result is
//    ready before the old one is taken.
//  - Reset (rst_n low, synchronous) empties the list and drops any pending
//    result; stored values are not cleared and are never read before written.
//  - Stalling out_ch holds the result steady and eventually stops in_ch.
`timescale 1ns / 1ps
`default_nettype none
module indexed_value_list_unit (
  input  wire          clk,
  input  wire          rst_n,
  ivl_in_if.sink       in_ch,
  ivl_out_if.source    out_ch
);

  localparam int DW = ivl_pkg::DATA_W;
  localparam int PW = ivl_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RES  = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  ivl_pkg::cmd_t               cmd_r;
  logic [PW-1:0]               pos_r;
  logic [DW-1:0]               val_r;
  logic [PW-1:0]               count_r, count_nxt;
  logic                        ok_r;
  logic                        rd_r;
  logic [ivl_pkg::GRP_W-1:0]   sel_r;
  logic [DW-1:0]               grp_r [ivl_pkg::NUM_GRP];
  logic [DW-1:0]               grp_nxt [ivl_pkg::NUM_GRP];

  logic                        out_valid_r;
  logic [DW-1:0]               out_value_r;
  logic                        out_ok_r;
  logic [PW-1:0]               out_len_r;

  logic                        accept;
  logic                        out_load;
  logic                        is_add, is_rem, is_read, is_clear;
  logic [PW-1:0]               eff_pos;
  logic                        cmd_ok;
  ivl_pkg::cell_cmd_t          cell_cmd;
  logic [DW-1:0]               cell_val [ivl_pkg::CAPACITY];

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_RES) && (!out_valid_r || out_ch.ready);

  // command decode and bounds checks
  always_comb begin
    is_add   = 1'b0;
    is_rem   = 1'b0;
    is_read  = 1'b0;
    is_clear = 1'b0;
    eff_pos  = pos_r;
    unique case (cmd_r)
      ivl_pkg::CMD_ADD_FRONT: begin
        is_add  = 1'b1;
        eff_pos = '0;
      end
      ivl_pkg::CMD_ADD_BACK: begin
        is_add  = 1'b1;
        eff_pos = count_r;
      end
      ivl_pkg::CMD_ADD_AT:    is_add = 1'b1;
      ivl_pkg::CMD_REM_FRONT: begin
        is_rem  = 1'b1;
        eff_pos = '0;
      end
      ivl_pkg::CMD_REM_BACK: begin
        is_rem  = 1'b1;
        eff_pos = count_r - PW'(1);
      end
      ivl_pkg::CMD_REM_AT:    is_rem   = 1'b1;
      ivl_pkg::CMD_READ:      is_read  = 1'b1;
      ivl_pkg::CMD_CLEAR:     is_clear = 1'b1;
      default:                is_clear = 1'b1;
    endcase
  end

  always_comb begin
    cmd_ok = 1'b0;
    if (is_add) begin
      cmd_ok = (count_r < ivl_pkg::CAP_COUNT) && (eff_pos <= count_r);
    end else if (is_rem || is_read) begin
      cmd_ok = (eff_pos < count_r);
    end else if (is_clear) begin
      cmd_ok = 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (state_r == S_EXEC && cmd_ok) begin
      if (is_add) begin
        count_nxt = count_r + PW'(1);
      end else if (is_rem) begin
        count_nxt = count_r - PW'(1);
      end else if (is_clear) begin
        count_nxt = '0;
      end
    end
  end

  always_comb begin
    cell_cmd.ins = (state_r == S_EXEC) && is_add && cmd_ok;
    cell_cmd.rem = (state_r == S_EXEC) && is_rem && cmd_ok;
    cell_cmd.pos = eff_pos;
    cell_cmd.val = val_r;
  end

  // cell chain
  for (genvar i = 0; i < ivl_pkg::CAPACITY; i++) begin : g_cell
    logic [DW-1:0] left_v;
    logic [DW-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == ivl_pkg::CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    ivl_cell u_cell (
      .clk       (clk),
      .cmd       (cell_cmd),
      .my_idx    (PW'(i)),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[i])
    );
  end

  // first select level: one entry per group of cells, taken before the shift
  always_comb begin
    for (int g = 0; g < ivl_pkg::NUM_GRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < ivl_pkg::GRP_SIZE; k++) begin
        if ((g * ivl_pkg::GRP_SIZE + k < ivl_pkg::CAPACITY) &&
            (eff_pos[ivl_pkg::SUB_W-1:0] == ivl_pkg::SUB_W'(k))) begin
          grp_nxt[g] = cell_val[g * ivl_pkg::GRP_SIZE + k];
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_RES;
      S_RES:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= ivl_pkg::cmd_t'(in_ch.cmd);
      pos_r <= in_ch.position;
      val_r <= in_ch.item_value;
    end
    if (state_r == S_EXEC) begin
      ok_r  <= cmd_ok;
      rd_r  <= cmd_ok && (is_rem || is_read);
      sel_r <= eff_pos[ivl_pkg::SUB_W +: ivl_pkg::GRP_W];
      for (int g = 0; g < ivl_pkg::NUM_GRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
    if (out_load) begin
      out_value_r <= rd_r ? grp_r[sel_r] : ivl_pkg::NEG_ONE;
      out_ok_r    <= ok_r;
      out_len_r   <= count_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_value_r;
  assign out_ch.ok         = out_ok_r;
  assign out_ch.length     = out_len_r;

`ifndef SYNTH
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ivl_pkg::CAP_COUNT)
    else $error("list length above capacity");

  a_fail_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> out_value_r == ivl_pkg::NEG_ONE)
    else $error("failed command with value other than -1");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("accepted command not executed");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire

// ----- sim/indexed_value_list_unit_tb.sv -----
// Self-checking testbench for indexed_value_list_unit: directed and random list commands
// over valid/ready channels, each result checked against an in-bench list model.
// Depends on ivl_pkg, ivl_if (ivl_in_if, ivl_out_if) and the RTL of the unit.
`timescale 1ns / 1ps
module indexed_value_list_unit_tb;

  typedef struct packed {
    logic signed [ivl_pkg::DATA_W-1:0] value;
    logic                              ok;
    logic [ivl_pkg::POS_W-1:0]         len;
  } list_result_t;

  localparam logic signed [ivl_pkg::DATA_W-1:0] VAL_MIN =
    {1'b1, {(ivl_pkg::DATA_W-1){1'b0}}};
  localparam logic signed [ivl_pkg::DATA_W-1:0] VAL_MAX =
    {1'b0, {(ivl_pkg::DATA_W-1){1'b1}}};
  localparam logic [ivl_pkg::POS_W-1:0]         POS_TOP = '1;

  localparam int RX_ALWAYS    = 0;
  localparam int RX_RANDOM    = 1;
  localparam int RX_PATTERN   = 2;
  localparam int DRAIN_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 20;
  localparam int HOLD_CYCLES  = 40;

  logic clk;
  logic rst_n;

  ivl_in_if  in_ch ();
  ivl_out_if out_ch ();

  indexed_value_list_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [ivl_pkg::DATA_W-1:0] shadow_list[$];
  list_result_t                      awaited_results[$];

  int errors          = 0;
  int results_checked = 0;
  int rejected_cmds   = 0;
  int peak_len        = 0;
  int cmd_seen[8];
  int burst_left      = 0;
  bit gaps_on         = 1'b0;
  int stall_mode      = RX_ALWAYS;
  int hold_cycles     = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Timeout at %0t with %0d results outstanding", $time, awaited_results.size());
    $display("[indexed_value_list_unit] ERROR");
    $finish;
  end

  // list model: applies one command, returns the result it must produce
  function automatic list_result_t list_apply(ivl_pkg::cmd_t c,
                                              logic [ivl_pkg::POS_W-1:0] pos,
                                              logic signed [ivl_pkg::DATA_W-1:0] v);
    list_result_t r;
    int           n;
    int           at;
    n       = shadow_list.size();
    r.value = ivl_pkg::NEG_ONE;
    r.ok    = 1'b0;
    case (c)
      ivl_pkg::CMD_ADD_FRONT, ivl_pkg::CMD_ADD_BACK, ivl_pkg::CMD_ADD_AT: begin
        at = (c == ivl_pkg::CMD_ADD_FRONT) ? 0 :
             (c == ivl_pkg::CMD_ADD_BACK) ? n : int'(pos);
        if (n < ivl_pkg::CAPACITY && at <= n) begin
          shadow_list.insert(at, v);
          r.ok = 1'b1;
        end
      end
      ivl_pkg::CMD_REM_FRONT, ivl_pkg::CMD_REM_BACK, ivl_pkg::CMD_REM_AT: begin
        at = (c == ivl_pkg::CMD_REM_FRONT) ? 0 :
             (c == ivl_pkg::CMD_REM_BACK) ? n - 1 : int'(pos);
        if (n > 0 && at < n) begin
          r.value = shadow_list[at];
          shadow_list.delete(at);
          r.ok = 1'b1;
        end
      end
      ivl_pkg::CMD_READ: begin
        if (int'(pos) < n) begin
          r.value = shadow_list[pos];
          r.ok    = 1'b1;
        end
      end
      default: begin
        shadow_list.delete();
        r.ok = 1'b1;
      end
    endcase
    r.len = ivl_pkg::POS_W'(shadow_list.size());
    return r;
  endfunction

  function automatic ivl_pkg::cmd_t pick_cmd(int add_pct, int rem_pct, int clear_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < add_pct)
      return ivl_pkg::cmd_t'(ivl_pkg::CMD_ADD_FRONT + $urandom_range(0, 2));
    if (r < add_pct + rem_pct)
      return ivl_pkg::cmd_t'(ivl_pkg::CMD_REM_FRONT + $urandom_range(0, 2));
    if (r < 100 - clear_pct) return ivl_pkg::CMD_READ;
    return ivl_pkg::CMD_CLEAR;
  endfunction

  function automatic logic [ivl_pkg::POS_W-1:0] pick_pos(ivl_pkg::cmd_t c);
    int n;
    int r;
    n = shadow_list.size();
    r = $urandom_range(0, 9);
    if (r == 9 ||
        !(c inside {ivl_pkg::CMD_ADD_AT, ivl_pkg::CMD_REM_AT, ivl_pkg::CMD_READ}))
      return ivl_pkg::POS_W'($urandom_range(0, 255));
    if (r == 8) return ivl_pkg::POS_W'(n + $urandom_range(0, 1));
    if (c == ivl_pkg::CMD_ADD_AT) return ivl_pkg::POS_W'($urandom_range(0, n));
    return (n == 0) ? '0 : ivl_pkg::POS_W'($urandom_range(0, n - 1));
  endfunction

  function automatic logic signed [ivl_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return ivl_pkg::NEG_ONE;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(ivl_pkg::cmd_t c, logic [ivl_pkg::POS_W-1:0] pos,
                          logic signed [ivl_pkg::DATA_W-1:0] v);
    int           gap;
    list_result_t r;
    gap = 0;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      if (gaps_on) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.position   <= pos;
    in_ch.item_value <= v;
    do @(posedge clk); while (!in_ch.ready);
    r = list_apply(c, pos, v);
    awaited_results.push_back(r);
    cmd_seen[c]++;
    if (!r.ok) rejected_cmds++;
    if (shadow_list.size() > peak_len) peak_len = shadow_list.size();
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
      awaited_results.delete();
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_checked++;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value %0d ok %0b length %0d", $time,
                 out_ch.read_value, out_ch.ok, out_ch.length);
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.read_value !== want.value) begin
          errors++;
          $display("%0t: read_value expected %0d got %0d", $time, want.value,
                   out_ch.read_value);
        end
        if (out_ch.ok !== want.ok) begin
          errors++;
          $display("%0t: ok expected %0b got %0b", $time, want.ok, out_ch.ok);
        end
        if (out_ch.length !== want.len) begin
          errors++;
          $display("%0t: length expected %0d got %0d", $time, want.len, out_ch.length);
        end
      end
    end
  end

  // receiver: long hold-offs when requested, otherwise its own stall pattern
  initial begin : result_receiver
    int  phase;
    logic rdy;
    phase = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        rdy = 1'b0;
      end else begin
        case (stall_mode)
          RX_RANDOM:  rdy = ($urandom_range(0, 3) != 0);
          RX_PATTERN: rdy = ((phase % 7) < 4);
          default:    rdy = 1'b1;
        endcase
      end
      phase++;
      out_ch.ready <= rdy;
    end
  end

  task automatic test_empty_list();
    gaps_on    = 1'b0;
    stall_mode = RX_ALWAYS;
    send_cmd(ivl_pkg::CMD_REM_FRONT, '0, '0);
    send_cmd(ivl_pkg::CMD_REM_BACK, '0, '0);
    send_cmd(ivl_pkg::CMD_REM_AT, '0, '0);
    send_cmd(ivl_pkg::CMD_READ, '0, '0);
    send_cmd(ivl_pkg::CMD_CLEAR, POS_TOP, VAL_MAX);
    drain_results();
  endtask

  task automatic test_edges();
    gaps_on    = 1'b1;
    stall_mode = RX_RANDOM;
    send_cmd(ivl_pkg::CMD_ADD_BACK, POS_TOP, VAL_MAX);
    send_cmd(ivl_pkg::CMD_ADD_FRONT, POS_TOP, VAL_MIN);
    send_cmd(ivl_pkg::CMD_ADD_AT, 8'd1, ivl_pkg::NEG_ONE);
    send_cmd(ivl_pkg::CMD_ADD_AT, 8'd3, '0);
    send_cmd(ivl_pkg::CMD_ADD_AT, 8'd5, 32'sd7);
    send_cmd(ivl_pkg::CMD_ADD_AT, POS_TOP, 32'sd7);
    send_cmd(ivl_pkg::CMD_READ, 8'd0, '0);
    send_cmd(ivl_pkg::CMD_READ, 8'd3, '0);
    send_cmd(ivl_pkg::CMD_READ, 8'd4, '0);
    send_cmd(ivl_pkg::CMD_READ, POS_TOP, '0);
    send_cmd(ivl_pkg::CMD_REM_AT, 8'd1, '0);
    send_cmd(ivl_pkg::CMD_REM_AT, 8'd3, '0);
    send_cmd(ivl_pkg::CMD_REM_FRONT, POS_TOP, '1);
    send_cmd(ivl_pkg::CMD_REM_BACK, POS_TOP, '1);
    send_cmd(ivl_pkg::CMD_REM_AT, 8'd0, '0);
    send_cmd(ivl_pkg::CMD_CLEAR, POS_TOP, '1);
    drain_results();
  endtask

  task automatic test_full_list();
    gaps_on    = 1'b0;
    stall_mode = RX_PATTERN;
    repeat (ivl_pkg::CAPACITY)
      send_cmd(ivl_pkg::CMD_ADD_BACK, pick_pos(ivl_pkg::CMD_ADD_BACK), pick_value());
    send_cmd(ivl_pkg::CMD_ADD_FRONT, '0, VAL_MIN);
    send_cmd(ivl_pkg::CMD_ADD_BACK, '0, VAL_MAX);
    send_cmd(ivl_pkg::CMD_ADD_AT, ivl_pkg::POS_W'(ivl_pkg::CAPACITY), 32'sd1);
    send_cmd(ivl_pkg::CMD_READ, ivl_pkg::POS_W'(ivl_pkg::CAPACITY - 1), '0);
    send_cmd(ivl_pkg::CMD_READ, ivl_pkg::POS_W'(ivl_pkg::CAPACITY), '0);
    send_cmd(ivl_pkg::CMD_REM_AT, ivl_pkg::POS_W'(ivl_pkg::CAPACITY - 1), '0);
    send_cmd(ivl_pkg::CMD_ADD_AT, ivl_pkg::POS_W'(ivl_pkg::CAPACITY - 1),
             ivl_pkg::NEG_ONE);
    send_cmd(ivl_pkg::CMD_REM_BACK, '0, '0);
    send_cmd(ivl_pkg::CMD_CLEAR, '0, '0);
    drain_results();
  endtask

  // receiver holds off while commands keep coming, so the input must stall
  task automatic test_backpressure();
    gaps_on     = 1'b0;
    stall_mode  = RX_ALWAYS;
    hold_cycles = HOLD_CYCLES;
    repeat (20)
      send_cmd(ivl_pkg::cmd_t'(ivl_pkg::CMD_ADD_FRONT + $urandom_range(0, 2)), '0,
               pick_value());
    drain_results();
  endtask

  task automatic test_random_phase(int count, int add_pct, int rem_pct, int clear_pct,
                                   bit gaps, int rx_mode);
    ivl_pkg::cmd_t c;
    gaps_on    = gaps;
    stall_mode = rx_mode;
    repeat (count) begin
      c = pick_cmd(add_pct, rem_pct, clear_pct);
      send_cmd(c, pick_pos(c), pick_value());
    end
    drain_results();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = ivl_pkg::CMD_CLEAR;
    in_ch.position   = '0;
    in_ch.item_value = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_edges();
    test_full_list();
    test_backpressure();
    test_random_phase(100, 70, 15, 0, 1'b1, RX_RANDOM);
    test_random_phase(100, 20, 60, 0, 1'b0, RX_ALWAYS);
    test_random_phase(100, 45, 35, 2, 1'b1, RX_PATTERN);
    test_random_phase(100, 60, 25, 0, 1'b1, RX_RANDOM);
    test_random_phase(100, 35, 40, 3, 1'b0, RX_ALWAYS);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d commands (add %0d/%0d/%0d, remove %0d/%0d/%0d, read %0d, clear %0d)",
             cmd_seen.sum(), cmd_seen[ivl_pkg::CMD_ADD_FRONT],
             cmd_seen[ivl_pkg::CMD_ADD_BACK], cmd_seen[ivl_pkg::CMD_ADD_AT],
             cmd_seen[ivl_pkg::CMD_REM_FRONT], cmd_seen[ivl_pkg::CMD_REM_BACK],
             cmd_seen[ivl_pkg::CMD_REM_AT], cmd_seen[ivl_pkg::CMD_READ],
             cmd_seen[ivl_pkg::CMD_CLEAR]);
    $display("%0d results checked, %0d commands rejected, list reached length %0d",
             results_checked, rejected_cmds, peak_len);
    if (errors == 0) begin
      $display("[indexed_value_list_unit] OK");
    end else begin
      $display("[indexed_value_list_unit] ERROR");
    end
    $finish;
  end

endmodule
